// ===== sv/bgwb_pkg.sv =====
package bgwb_pkg;

  localparam int PIX_W    = 8;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 1;
  localparam int GAIN_W   = 16;
  localparam int SUM_RB_W = 30;
  localparam int SUM_G_W  = 31;
  localparam int MUL_W    = 16;

  localparam int DEF_MAX_DIMENSION      = 4096;
  localparam int DEF_GAIN_FRACTION_BITS = 12;

  localparam logic [PIX_W-1:0]  BLACK_LEVEL = 8'd16;
  localparam logic [PIX_W-1:0]  PIX_MAX     = 8'd255;
  localparam logic [GAIN_W-1:0] GAIN_MAX    = 16'hFFFF;
  localparam logic [CFG_W-1:0]  WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0]  HEIGHT_RESET = 13'd200;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

  localparam logic OP_APPLY   = 1'b0;
  localparam logic OP_MEASURE = 1'b1;

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_MUL_R     = 8'b0000_0010,
    ST_MUL_B     = 8'b0000_0100,
    ST_APPLY_OUT = 8'b0000_1000,
    ST_AREA      = 8'b0001_0000,
    ST_DIV_START = 8'b0010_0000,
    ST_DIV_WAIT  = 8'b0100_0000,
    ST_MEAS_OUT  = 8'b1000_0000
  } state_e;

  typedef enum logic [2:0] {
    STEP_AVG_R  = 3'd0,
    STEP_AVG_B  = 3'd1,
    STEP_AVG_G  = 3'd2,
    STEP_GAIN_R = 3'd3,
    STEP_GAIN_B = 3'd4
  } step_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [PIX_W-1:0] black_sub(input logic [PIX_W-1:0] p);
    black_sub = (p >= BLACK_LEVEL) ? p - BLACK_LEVEL : '0;
  endfunction

endpackage

// ===== sv/bayer_gray_world_white_balance.sv =====
// Channel  Direction  Handshake                  Payload
// cfg      in         cfg_we_i                   cfg_index_i, cfg_wdata_i
// in       in         in_valid_i / in_ready_o    operation_i, four pixels, last_quad_i
// out      out        out_valid_o / out_ready_i  four pixels, gains_updated_o, gains, zero flag
//
// An apply beat uses the shared multiplier for red, then blue.
// A measure beat that is not last only adds to the sums, leaves the block ready and produces no result.
// A last measure beat runs the bit-serial divider for five divisions one after another:
// the red, blue and green averages, then the red and blue gains.
// Reset is asynchronous and active low; it restores unity gains, zero sums and default sizes.
// A result waiting in the output register does not stop the next beat from being taken.
module bayer_gray_world_white_balance import bgwb_pkg::*; #(
  parameter int MAX_DIMENSION      = DEF_MAX_DIMENSION,
  parameter int GAIN_FRACTION_BITS = DEF_GAIN_FRACTION_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 operation_i,
  input  logic [PIX_W-1:0]     red_in_i,
  input  logic [PIX_W-1:0]     green_red_row_in_i,
  input  logic [PIX_W-1:0]     green_blue_row_in_i,
  input  logic [PIX_W-1:0]     blue_in_i,
  input  logic                 last_quad_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [PIX_W-1:0]     red_out_o,
  output logic [PIX_W-1:0]     green_red_row_out_o,
  output logic [PIX_W-1:0]     green_blue_row_out_o,
  output logic [PIX_W-1:0]     blue_out_o,
  output logic                 gains_updated_o,
  output logic [GAIN_W-1:0]    new_gain_red_o,
  output logic [GAIN_W-1:0]    new_gain_blue_o,
  output logic                 zero_average_o
);

  localparam int DND_W = SUM_G_W + GAIN_FRACTION_BITS;
  localparam int DSR_W = SUM_RB_W;
  localparam logic [GAIN_W-1:0] GainUnity = (GAIN_FRACTION_BITS >= GAIN_W) ?
      GAIN_MAX : GAIN_W'(64'd1 << GAIN_FRACTION_BITS);

  state_e state_q, state_d;
  step_e  step_q;

  logic [CFG_W-1:0]    frame_width_q, frame_height_q;
  logic [SUM_RB_W-1:0] sum_red_q, sum_blue_q;
  logic [SUM_G_W-1:0]  sum_green_q;
  logic [GAIN_W-1:0]   gain_red_q, gain_blue_q;
  logic [SUM_RB_W-1:0] avg_r_q, avg_b_q;
  logic [SUM_G_W-1:0]  avg_g_q;
  logic                zero_q;

  logic [PIX_W-1:0] px_r_q, px_gr_q, px_gb_q, px_b_q, red_res_q;
  logic [2*MUL_W-1:0] mul_q;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] scaled;
  logic [PIX_W-1:0]   scaled_sat;

  logic out_valid_q, gains_updated_q, zero_average_q;
  logic [PIX_W-1:0]  red_out_q, gr_out_q, gb_out_q, blue_out_q;
  logic [GAIN_W-1:0] new_gain_red_q, new_gain_blue_q;

  logic in_acc, out_free, out_load;
  logic [CFG_W-1:0] dim_w, dim_h;
  logic [SUM_RB_W:0] sum_r_add, sum_b_add;
  logic [SUM_G_W:0]  sum_g_add;
  logic [SUM_RB_W-1:0] sum_r_sat, sum_b_sat;
  logic [SUM_G_W-1:0]  sum_g_sat;

  div_stat_t        div_stat;
  logic             div_start;
  logic [DND_W-1:0] div_dividend, div_quo;
  logic [DSR_W-1:0] div_divisor;
  logic             div_zero;
  logic [GAIN_W-1:0] gain_res;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign dim_w = ({1'b0, frame_width_q} > (CFG_W+1)'(MAX_DIMENSION)) ?
                 CFG_W'(MAX_DIMENSION) : frame_width_q;
  assign dim_h = ({1'b0, frame_height_q} > (CFG_W+1)'(MAX_DIMENSION)) ?
                 CFG_W'(MAX_DIMENSION) : frame_height_q;

  assign sum_r_add = {1'b0, sum_red_q} + (SUM_RB_W+1)'(red_in_i);
  assign sum_b_add = {1'b0, sum_blue_q} + (SUM_RB_W+1)'(blue_in_i);
  assign sum_g_add = {1'b0, sum_green_q} + (SUM_G_W+1)'(green_red_row_in_i)
                   + (SUM_G_W+1)'(green_blue_row_in_i);
  assign sum_r_sat = sum_r_add[SUM_RB_W] ? '1 : sum_r_add[SUM_RB_W-1:0];
  assign sum_b_sat = sum_b_add[SUM_RB_W] ? '1 : sum_b_add[SUM_RB_W-1:0];
  assign sum_g_sat = sum_g_add[SUM_G_W] ? '1 : sum_g_add[SUM_G_W-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MUL_R: begin
        mul_a = MUL_W'(px_r_q);
        mul_b = gain_red_q;
      end
      ST_MUL_B: begin
        mul_a = MUL_W'(px_b_q);
        mul_b = gain_blue_q;
      end
      ST_AREA: begin
        mul_a = MUL_W'(dim_w);
        mul_b = MUL_W'(dim_h);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign scaled     = mul_q >> GAIN_FRACTION_BITS;
  assign scaled_sat = (scaled > (2*MUL_W)'(PIX_MAX)) ? PIX_MAX : scaled[PIX_W-1:0];

  always_comb begin
    div_dividend = '0;
    div_divisor  = '0;
    case (step_q)
      STEP_AVG_R: begin
        div_dividend = DND_W'(sum_red_q);
        div_divisor  = DSR_W'(mul_q >> 2);
      end
      STEP_AVG_B: begin
        div_dividend = DND_W'(sum_blue_q);
        div_divisor  = DSR_W'(mul_q >> 2);
      end
      STEP_AVG_G: begin
        div_dividend = DND_W'(sum_green_q);
        div_divisor  = DSR_W'(mul_q >> 1);
      end
      STEP_GAIN_R: begin
        div_dividend = {avg_g_q, {GAIN_FRACTION_BITS{1'b0}}};
        div_divisor  = avg_r_q;
      end
      STEP_GAIN_B: begin
        div_dividend = {avg_g_q, {GAIN_FRACTION_BITS{1'b0}}};
        div_divisor  = avg_b_q;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
  end

  assign div_start = (state_q == ST_DIV_START);
  assign div_zero  = (div_divisor == '0);
  assign gain_res  = (div_zero || (div_quo[DND_W-1:GAIN_W] != '0)) ?
                     GAIN_MAX : div_quo[GAIN_W-1:0];

  bgwb_div #(
    .DND_W(DND_W),
    .DSR_W(DSR_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .stat_o    (div_stat),
    .quotient_o(div_quo)
  );

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (operation_i == OP_APPLY) begin
            state_d = ST_MUL_R;
          end else if (last_quad_i) begin
            state_d = ST_AREA;
          end
        end
      end
      ST_MUL_R:     state_d = ST_MUL_B;
      ST_MUL_B:     state_d = ST_APPLY_OUT;
      ST_APPLY_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_AREA:      state_d = ST_DIV_START;
      ST_DIV_START: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_d = (step_q == STEP_GAIN_B) ? ST_MEAS_OUT : ST_DIV_START;
        end
      end
      ST_MEAS_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      step_q         <= STEP_AVG_R;
      frame_width_q  <= WIDTH_RESET;
      frame_height_q <= HEIGHT_RESET;
      sum_red_q      <= '0;
      sum_green_q    <= '0;
      sum_blue_q     <= '0;
      gain_red_q     <= GainUnity;
      gain_blue_q    <= GainUnity;
      zero_q         <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_IDX_WIDTH) begin
          frame_width_q <= cfg_wdata_i;
        end else begin
          frame_height_q <= cfg_wdata_i;
        end
      end
      if (in_acc && (operation_i == OP_MEASURE)) begin
        sum_red_q   <= sum_r_sat;
        sum_green_q <= sum_g_sat;
        sum_blue_q  <= sum_b_sat;
      end
      if (state_q == ST_AREA) begin
        step_q <= STEP_AVG_R;
        zero_q <= 1'b0;
      end
      if ((state_q == ST_DIV_WAIT) && div_stat.done) begin
        case (step_q)
          STEP_AVG_R:  step_q <= STEP_AVG_B;
          STEP_AVG_B:  step_q <= STEP_AVG_G;
          STEP_AVG_G:  step_q <= STEP_GAIN_R;
          STEP_GAIN_R: begin
            step_q     <= STEP_GAIN_B;
            gain_red_q <= gain_res;
            if (div_zero) begin
              zero_q <= 1'b1;
            end
          end
          STEP_GAIN_B: begin
            gain_blue_q <= gain_res;
            if (div_zero) begin
              zero_q <= 1'b1;
            end
          end
          default:     step_q <= STEP_AVG_R;
        endcase
      end
      if ((state_q == ST_MEAS_OUT) && out_load) begin
        sum_red_q   <= '0;
        sum_green_q <= '0;
        sum_blue_q  <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_r_q  <= black_sub(red_in_i);
      px_gr_q <= black_sub(green_red_row_in_i);
      px_gb_q <= black_sub(green_blue_row_in_i);
      px_b_q  <= black_sub(blue_in_i);
    end
    if ((state_q == ST_MUL_R) || (state_q == ST_MUL_B) || (state_q == ST_AREA)) begin
      mul_q <= mul_a * mul_b;
    end
    if (state_q == ST_MUL_B) begin
      red_res_q <= scaled_sat;
    end
    if ((state_q == ST_DIV_WAIT) && div_stat.done) begin
      case (step_q)
        STEP_AVG_R: avg_r_q <= div_zero ? '0 : SUM_RB_W'(div_quo);
        STEP_AVG_B: avg_b_q <= div_zero ? '0 : SUM_RB_W'(div_quo);
        STEP_AVG_G: avg_g_q <= div_zero ? '0 : SUM_G_W'(div_quo);
        default: begin
        end
      endcase
    end
    if (out_load) begin
      gr_out_q <= px_gr_q;
      gb_out_q <= px_gb_q;
      if (state_q == ST_APPLY_OUT) begin
        red_out_q       <= red_res_q;
        blue_out_q      <= scaled_sat;
        gains_updated_q <= 1'b0;
        new_gain_red_q  <= '0;
        new_gain_blue_q <= '0;
        zero_average_q  <= 1'b0;
      end else begin
        red_out_q       <= '0;
        blue_out_q      <= '0;
        gains_updated_q <= 1'b1;
        new_gain_red_q  <= gain_red_q;
        new_gain_blue_q <= gain_blue_q;
        zero_average_q  <= zero_q;
      end
    end
  end

  assign out_valid_o          = out_valid_q;
  assign red_out_o            = red_out_q;
  assign green_red_row_out_o  = gr_out_q;
  assign green_blue_row_out_o = gb_out_q;
  assign blue_out_o           = blue_out_q;
  assign gains_updated_o      = gains_updated_q;
  assign new_gain_red_o       = new_gain_red_q;
  assign new_gain_blue_o      = new_gain_blue_q;
  assign zero_average_o       = zero_average_q;

  a_apply_starts_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (operation_i == OP_APPLY)) |=> (state_q == ST_MUL_R))
    else $error("apply beat did not start the red multiply");

  a_measure_not_last_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (operation_i == OP_MEASURE) && !last_quad_i) |=> in_ready_o)
    else $error("measure beat without last left the block busy");

  a_div_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_gain_fields_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !gains_updated_o) |->
      (!zero_average_o && (new_gain_red_o == '0) && (new_gain_blue_o == '0)))
    else $error("apply result carries gain fields");

  a_measure_pixels_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && gains_updated_o) |-> ((red_out_o == '0) && (blue_out_o == '0)))
    else $error("measure result carries red or blue pixels");

endmodule

// ===== sv/bgwb_div.sv =====
module bgwb_div import bgwb_pkg::*; #(
  parameter int DND_W = 43,
  parameter int DSR_W = 30
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DND_W-1:0] dividend_i,
  input  logic [DSR_W-1:0] divisor_i,
  output div_stat_t        stat_o,
  output logic [DND_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DND_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DSR_W-1:0] rem_q;
  logic [DSR_W-1:0] dsr_q;
  logic [DND_W-1:0] quo_q;
  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;

  assign trial = {rem_q, quo_q[DND_W-1]};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DND_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dsr_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      if (!diff[DSR_W]) begin
        rem_q <= diff[DSR_W-1:0];
        quo_q <= {quo_q[DND_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[DSR_W-1:0];
        quo_q <= {quo_q[DND_W-2:0], 1'b0};
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule
